### hdl/grid_pool_and_level_lists_unit_macros.svh
// Assertion macros for the grid pool and level list unit.
// Used by the top level only; needs nothing else.
`ifndef GRID_POOL_AND_LEVEL_LISTS_UNIT_MACROS_SVH
`define GRID_POOL_AND_LEVEL_LISTS_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GPL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define GPL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gpl_pkg.sv
// Shared types, constants and count helpers for the grid pool unit.
// Depends on nothing; used by the top level and gpl_level_lists.
`default_nettype none

package gpl_pkg;

  localparam int unsigned POOL_SLOTS_DEF = 4096;
  localparam int unsigned LEVEL_MAX_DEF  = 16;

  localparam int unsigned SLOT_IN_W = 13;
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned COUNT_W   = 13;

  localparam logic [COUNT_W-1:0] COUNT_TOP = 13'h1FFF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_APPEND  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // view of one level list
  typedef struct packed {
    logic                 used;
    logic [SLOT_IN_W-1:0] tail;
    logic [COUNT_W-1:0]   count;
  } lvl_view_t;

  // append of one slot to a level list
  typedef struct packed {
    logic                 en;
    logic [LEVEL_W-1:0]   lvl;
    logic [SLOT_IN_W-1:0] slot;
  } lvl_upd_t;

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    return (c == COUNT_TOP) ? COUNT_TOP : c + COUNT_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] c);
    return (c == '0) ? '0 : c - COUNT_W'(1);
  endfunction

  function automatic logic level_ok(input logic [LEVEL_W-1:0] lvl,
                                    input int unsigned level_max);
    return 32'(lvl) <= level_max;
  endfunction

endpackage

`default_nettype wire

### hdl/grid_pool_and_level_lists_unit.sv
// Top level of the grid pool unit: request sequencer, free list registers,
// result register. Depends on gpl_pkg, gpl_link_mem, gpl_level_lists and the macro header.
//
// Usage:
//   Requests enter on in_valid/in_ready with opcode, slot_id and level_sel;
//   results leave on out_valid/out_ready, one result per request.
//   Every request passes ST_IDLE and then ST_STEP: the accept cycle does the
//   first access to the next-link memory (head read for allocate, tail link
//   write for release and append), and ST_STEP consumes the registered read
//   data or does the second write and loads the result register. A new request
//   is not taken before the last one has left ST_STEP, as the link memory has a single port pair.
//   A new request is taken while a finished result waits in the result
//   register; when that register is still full in ST_STEP, the sequencer
//   holds until out_ready frees it.
//   After rst the link memory is initialized in ST_CLEAR, one entry per
//   cycle, with in_ready low; free list and level counts are set at once
//   by the reset itself.
`default_nettype none

`include "grid_pool_and_level_lists_unit_macros.svh"

module grid_pool_and_level_lists_unit #(
  parameter int unsigned POOL_SLOTS = gpl_pkg::POOL_SLOTS_DEF,
  parameter int unsigned LEVEL_MAX  = gpl_pkg::LEVEL_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      opcode,
  input  wire logic [gpl_pkg::SLOT_IN_W-1:0]   slot_id,
  input  wire logic [gpl_pkg::LEVEL_W-1:0]     level_sel,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [gpl_pkg::SLOT_IN_W-1:0]        granted_slot,
  output logic                                 pool_empty,
  output logic                                 request_bad,
  output logic [gpl_pkg::COUNT_W-1:0]          free_total,
  output logic [gpl_pkg::COUNT_W-1:0]          level_total
);

  localparam int unsigned SLOT_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned ADDR_W = $clog2(POOL_SLOTS);
  localparam logic [gpl_pkg::COUNT_W-1:0] FREE_INIT =
    (POOL_SLOTS > 32'(gpl_pkg::COUNT_TOP)) ? gpl_pkg::COUNT_TOP
                                           : gpl_pkg::COUNT_W'(POOL_SLOTS);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_STEP} state_t;

  state_t state;

  logic [ADDR_W-1:0]                clr_addr;
  logic [SLOT_W-1:0]                free_head;
  logic [SLOT_W-1:0]                free_tail;
  logic [gpl_pkg::COUNT_W-1:0]      free_count;

  gpl_pkg::op_t                     req_op;
  logic [gpl_pkg::SLOT_IN_W-1:0]    req_slot;
  logic [gpl_pkg::LEVEL_W-1:0]      req_lvl;
  logic                             req_ok;

  logic [SLOT_W-1:0]                free_head_next;
  logic [SLOT_W-1:0]                free_tail_next;
  logic [gpl_pkg::COUNT_W-1:0]      free_count_next;
  logic                             req_ok_next;

  logic                             mem_wr_en;
  logic [ADDR_W-1:0]                mem_wr_addr;
  logic [SLOT_W-1:0]                mem_wr_data;
  logic                             mem_rd_en;
  logic [ADDR_W-1:0]                mem_rd_addr;
  logic [SLOT_W-1:0]                mem_rd_data;

  logic [gpl_pkg::LEVEL_W-1:0]      view_lvl;
  gpl_pkg::lvl_view_t               lvl_view;
  gpl_pkg::lvl_upd_t                lvl_upd;

  logic                             in_slot_ok;
  logic                             in_lvl_ok;
  logic                             head_ok;
  logic                             tail_ok;
  logic                             clr_last;
  logic                             fire;

  logic [gpl_pkg::SLOT_IN_W-1:0]    res_granted;
  logic                             res_empty;
  logic                             res_bad;
  logic [gpl_pkg::COUNT_W-1:0]      res_level;

  gpl_link_mem #(
    .DEPTH  (POOL_SLOTS),
    .ADDR_W (ADDR_W),
    .DATA_W (SLOT_W)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  gpl_level_lists #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_level_lists (
    .clk    (clk),
    .rst    (rst),
    .rd_lvl (view_lvl),
    .view   (lvl_view),
    .upd    (lvl_upd)
  );

  assign in_ready = (state == ST_IDLE);
  assign view_lvl = (state == ST_IDLE) ? level_sel : req_lvl;

  always_comb begin
    in_slot_ok = (slot_id != '0) && (32'(slot_id) <= POOL_SLOTS);
    in_lvl_ok  = gpl_pkg::level_ok(level_sel, LEVEL_MAX);
    head_ok    = (free_head != '0) && (32'(free_head) <= POOL_SLOTS);
    tail_ok    = (free_tail != '0) && (32'(free_tail) <= POOL_SLOTS);
    clr_last   = (clr_addr == ADDR_W'(POOL_SLOTS - 1));
    fire       = (state == ST_STEP) && (!out_valid || out_ready);

    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;

    case (gpl_pkg::op_t'(opcode))
      gpl_pkg::OP_ALLOC:   req_ok_next = head_ok;
      gpl_pkg::OP_RELEASE: req_ok_next = in_slot_ok;
      gpl_pkg::OP_APPEND:  req_ok_next = in_slot_ok && in_lvl_ok;
      default:             req_ok_next = 1'b0;
    endcase

    case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = clr_last ? '0 : SLOT_W'(clr_addr) + SLOT_W'(2);
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (gpl_pkg::op_t'(opcode))
            gpl_pkg::OP_ALLOC: begin
              mem_rd_en   = head_ok;
              mem_rd_addr = ADDR_W'(free_head - SLOT_W'(1));
            end
            gpl_pkg::OP_RELEASE: begin
              // link the old free tail to the slot
              mem_wr_en   = in_slot_ok && tail_ok;
              mem_wr_addr = ADDR_W'(free_tail - SLOT_W'(1));
              mem_wr_data = SLOT_W'(slot_id);
            end
            gpl_pkg::OP_APPEND: begin
              mem_wr_en   = in_slot_ok && in_lvl_ok && lvl_view.used;
              mem_wr_addr = ADDR_W'(lvl_view.tail - gpl_pkg::SLOT_IN_W'(1));
              mem_wr_data = SLOT_W'(slot_id);
            end
            default: begin
            end
          endcase
        end
      end
      ST_STEP: begin
        // terminate the slot that left or joined a list
        if (fire && req_ok) begin
          mem_wr_en = 1'b1;
          if (req_op == gpl_pkg::OP_ALLOC) begin
            mem_wr_addr = ADDR_W'(free_head - SLOT_W'(1));
          end else begin
            mem_wr_addr = ADDR_W'(req_slot - gpl_pkg::SLOT_IN_W'(1));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    free_head_next  = free_head;
    free_tail_next  = free_tail;
    free_count_next = free_count;
    lvl_upd         = '0;

    if (req_ok) begin
      case (req_op)
        gpl_pkg::OP_ALLOC: begin
          free_head_next  = mem_rd_data;
          if (mem_rd_data == '0) begin
            free_tail_next = '0;
          end
          free_count_next = gpl_pkg::count_down(free_count);
        end
        gpl_pkg::OP_RELEASE: begin
          if (free_tail == '0) begin
            free_head_next = SLOT_W'(req_slot);
          end
          free_tail_next  = SLOT_W'(req_slot);
          free_count_next = gpl_pkg::count_up(free_count);
        end
        gpl_pkg::OP_APPEND: begin
          lvl_upd.en   = fire;
          lvl_upd.lvl  = req_lvl;
          lvl_upd.slot = req_slot;
        end
        default: begin
        end
      endcase
    end

    res_granted = (req_op == gpl_pkg::OP_ALLOC && req_ok)
                  ? gpl_pkg::SLOT_IN_W'(free_head) : '0;
    res_empty   = (req_op == gpl_pkg::OP_ALLOC) && !req_ok;
    res_bad     = (req_op == gpl_pkg::OP_RELEASE || req_op == gpl_pkg::OP_APPEND) && !req_ok;
    res_level   = (req_op == gpl_pkg::OP_APPEND && req_ok)
                  ? gpl_pkg::count_up(lvl_view.count) : lvl_view.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      free_head  <= SLOT_W'(1);
      free_tail  <= SLOT_W'(POOL_SLOTS);
      free_count <= FREE_INIT;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_op   <= gpl_pkg::op_t'(opcode);
            req_slot <= slot_id;
            req_lvl  <= level_sel;
            req_ok   <= req_ok_next;
            state    <= ST_STEP;
          end
        end
        ST_STEP: begin
          // hold until the result register is free
          if (fire) begin
            free_head    <= free_head_next;
            free_tail    <= free_tail_next;
            free_count   <= free_count_next;
            granted_slot <= res_granted;
            pool_empty   <= res_empty;
            request_bad  <= res_bad;
            free_total   <= free_count_next;
            level_total  <= res_level;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `GPL_ASSERT_NXT(a_accept_steps, clk, rst, in_valid && in_ready, state == ST_STEP, "request accepted but sequencer did not advance")
  `GPL_ASSERT_IMP(a_empty_no_grant, clk, rst, out_valid && pool_empty, granted_slot == '0 && !request_bad, "empty pool result carries a slot or bad flag")
  `GPL_ASSERT_IMP(a_bad_no_grant, clk, rst, out_valid && request_bad, granted_slot == '0 && !pool_empty, "ignored request reports a grant")
  `GPL_ASSERT_IMP(a_head_tail, clk, rst, free_head == '0, free_tail == '0, "free list head is empty but tail is not")

endmodule

`default_nettype wire

### hdl/gpl_link_mem.sv
// Next-link store: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module gpl_link_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 13
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/gpl_level_lists.sv
// Per-level list state: used flag, tail slot and saturating count per level.
// Depends on gpl_pkg.
`default_nettype none

module gpl_level_lists #(
  parameter int unsigned LEVEL_MAX = gpl_pkg::LEVEL_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [gpl_pkg::LEVEL_W-1:0]  rd_lvl,
  output gpl_pkg::lvl_view_t                view,
  input  gpl_pkg::lvl_upd_t                 upd
);

  // levels above the 5-bit select range can never be addressed
  localparam int unsigned LVL_DEPTH = (LEVEL_MAX + 1 < 32) ? LEVEL_MAX + 1 : 32;
  localparam int unsigned IDX_W     = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

  logic [LVL_DEPTH-1:0]              used;
  logic [gpl_pkg::SLOT_IN_W-1:0]     tail  [LVL_DEPTH];
  logic [gpl_pkg::COUNT_W-1:0]       count [LVL_DEPTH];

  logic             rd_ok;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    rd_ok  = gpl_pkg::level_ok(rd_lvl, LEVEL_MAX);
    rd_idx = rd_ok ? IDX_W'(rd_lvl) : '0;
    wr_idx = IDX_W'(upd.lvl);
    if (rd_ok) begin
      view.used  = used[rd_idx];
      view.tail  = tail[rd_idx];
      view.count = count[rd_idx];
    end else begin
      view = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int i = 0; i < LVL_DEPTH; i++) begin
        count[i] <= '0;
      end
    end else if (upd.en) begin
      used[wr_idx]  <= 1'b1;
      tail[wr_idx]  <= upd.slot;
      count[wr_idx] <= gpl_pkg::count_up(count[wr_idx]);
    end
  end

endmodule

`default_nettype wire

### sim/tb_grid_pool_and_level_lists_unit.sv
// Self-checking bench for grid_pool_and_level_lists_unit: randomized request and result
// handshakes, checked against an in-bench model of the free list and level lists.
// Depends on gpl_pkg and the RTL of the unit only.
module tb_grid_pool_and_level_lists_unit;

  localparam int unsigned POOL      = gpl_pkg::POOL_SLOTS_DEF;
  localparam int unsigned LEVEL_TOP = gpl_pkg::LEVEL_MAX_DEF;
  localparam int unsigned REQ_TOTAL = 1050;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    gpl_pkg::op_t op;
    logic [12:0]  slot;
    logic [4:0]   lvl;
  } pool_req_t;

  typedef struct {
    logic [12:0] granted;
    logic        dry;
    logic        bad;
    logic [12:0] free_tot;
    logic [12:0] lvl_tot;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [12:0] slot_id = '0;
  logic [4:0] level_sel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [12:0] granted_slot;
  logic pool_empty;
  logic request_bad;
  logic [12:0] free_total;
  logic [12:0] level_total;

  grid_pool_and_level_lists_unit #(
    .POOL_SLOTS(POOL),
    .LEVEL_MAX (LEVEL_TOP)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .slot_id     (slot_id),
    .level_sel   (level_sel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .granted_slot(granted_slot),
    .pool_empty  (pool_empty),
    .request_bad (request_bad),
    .free_total  (free_total),
    .level_total (level_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Two copies of the pool state: copy 0 follows accepted requests for checking,
  // copy 1 is run ahead by the stimulus generator to know which slots get handed out.
  logic [12:0] nxt [0:1][1:POOL];
  logic [12:0] prv [0:1][1:POOL];
  logic [12:0] fhead [0:1];
  logic [12:0] ftail [0:1];
  logic [12:0] fcount [0:1];
  logic [12:0] lhead [0:1][0:LEVEL_TOP];
  logic [12:0] ltail [0:1][0:LEVEL_TOP];
  logic [12:0] lcount [0:1][0:LEVEL_TOP];

  pool_req_t    req_pending [$];
  pool_result_t due_results [$];
  logic [12:0]  held [$];
  pool_req_t    cur_req;
  pool_result_t head_res;
  pool_result_t acc_res;

  int unsigned sent_total = 0;
  int unsigned taken_total = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit req_taken = 1'b0;
  bit res_taken = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_hold = 0;

  function automatic logic in_pool(input logic [12:0] s);
    return s >= 13'd1 && 32'(s) <= POOL;
  endfunction

  function automatic logic [12:0] bump_up(input logic [12:0] c);
    return (c == 13'h1FFF) ? c : c + 13'd1;
  endfunction

  function automatic logic [12:0] bump_down(input logic [12:0] c);
    return (c == 13'd0) ? c : c - 13'd1;
  endfunction

  function automatic logic [4:0] pick_level();
    return ($urandom_range(0, 5) == 0) ? 5'($urandom_range(LEVEL_TOP + 1, 31))
                                       : 5'($urandom_range(0, LEVEL_TOP));
  endfunction

  task automatic pool_reset(input int cp);
    for (int unsigned i = 1; i <= POOL; i++) begin
      nxt[cp][i] = (i < POOL) ? 13'(i + 1) : 13'd0;
      prv[cp][i] = 13'(i - 1);
    end
    fhead[cp] = 13'd1;
    ftail[cp] = 13'(POOL);
    fcount[cp] = 13'(POOL);
    for (int i = 0; i <= LEVEL_TOP; i++) begin
      lhead[cp][i] = '0;
      ltail[cp][i] = '0;
      lcount[cp][i] = '0;
    end
  endtask

  task automatic pool_apply(input int cp, input pool_req_t rq, output pool_result_t r);
    logic [12:0] g;
    logic [12:0] s;
    logic lvl_ok;
    int li;
    s = rq.slot;
    li = rq.lvl;
    lvl_ok = 32'(rq.lvl) <= LEVEL_TOP;
    r = '{default: '0};
    case (rq.op)
      gpl_pkg::OP_ALLOC: begin
        if (!in_pool(fhead[cp])) begin
          r.dry = 1'b1;
        end else begin
          g = fhead[cp];
          r.granted = g;
          fhead[cp] = nxt[cp][g];
          if (fhead[cp] == 13'd0) ftail[cp] = 13'd0;
          else if (in_pool(fhead[cp])) prv[cp][fhead[cp]] = 13'd0;
          nxt[cp][g] = 13'd0;
          prv[cp][g] = 13'd0;
          fcount[cp] = bump_down(fcount[cp]);
        end
      end
      gpl_pkg::OP_RELEASE: begin
        if (!in_pool(s)) begin
          r.bad = 1'b1;
        end else begin
          if (ftail[cp] == 13'd0) begin
            fhead[cp] = s;
            prv[cp][s] = 13'd0;
          end else begin
            if (in_pool(ftail[cp])) nxt[cp][ftail[cp]] = s;
            prv[cp][s] = ftail[cp];
          end
          nxt[cp][s] = 13'd0;
          ftail[cp] = s;
          fcount[cp] = bump_up(fcount[cp]);
        end
      end
      gpl_pkg::OP_APPEND: begin
        if (!in_pool(s) || !lvl_ok) begin
          r.bad = 1'b1;
        end else begin
          if (lhead[cp][li] == 13'd0) begin
            lhead[cp][li] = s;
            prv[cp][s] = 13'd0;
          end else begin
            if (in_pool(ltail[cp][li])) nxt[cp][ltail[cp][li]] = s;
            prv[cp][s] = ltail[cp][li];
          end
          nxt[cp][s] = 13'd0;
          ltail[cp][li] = s;
          lcount[cp][li] = bump_up(lcount[cp][li]);
        end
      end
      default: ;
    endcase
    r.free_tot = fcount[cp];
    r.lvl_tot = lvl_ok ? lcount[cp][li] : 13'd0;
  endtask

  task automatic queue_req(input gpl_pkg::op_t op, input logic [12:0] s,
                           input logic [4:0] l, output pool_result_t r);
    pool_req_t rq;
    rq.op = op;
    rq.slot = s;
    rq.lvl = l;
    pool_apply(1, rq, r);
    req_pending.push_back(rq);
    sent_total++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [12:0] got,
                             input logic [12:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d (result %0d)", name, got, want,
                                taken_total));
  endtask

  // request driver: hold until accepted, then wait the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (req_pending.size() != 0) begin
        cur_req = req_pending.pop_front();
        opcode <= cur_req.op;
        slot_id <= cur_req.slot;
        level_sel <= cur_req.lvl;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : $urandom_range(0, 10);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // check results first, then predict the request accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        res_taken = 1'b1;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, slot %0d",
                                    granted_slot));
        end else begin
          head_res = due_results.pop_front();
          check_field("granted_slot", granted_slot, head_res.granted);
          check_field("pool_empty", 13'(pool_empty), 13'(head_res.dry));
          check_field("request_bad", 13'(request_bad), 13'(head_res.bad));
          check_field("free_total", free_total, head_res.free_tot);
          check_field("level_total", level_total, head_res.lvl_tot);
        end
      end
      if (in_valid && in_ready) begin
        pool_apply(0, cur_req, acc_res);
        due_results.push_back(acc_res);
        req_taken = 1'b1;
        taken_total++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    pool_result_t r;
    int unsigned pick;
    int unsigned idx;
    logic [12:0] s;

    pool_reset(0);
    pool_reset(1);

    // directed: field extremes, bad slots and levels, unused opcode,
    // releasing a free slot, emptying the pool through a cut free list
    queue_req(gpl_pkg::OP_ALLOC, 13'd0, 5'd0, r);
    queue_req(gpl_pkg::OP_ALLOC, 13'h1FFF, 5'd31, r);
    queue_req(gpl_pkg::OP_APPEND, 13'd1, 5'd0, r);
    queue_req(gpl_pkg::OP_APPEND, 13'd2, 5'(LEVEL_TOP), r);
    queue_req(gpl_pkg::OP_APPEND, 13'(POOL), 5'(LEVEL_TOP + 1), r);
    queue_req(gpl_pkg::OP_APPEND, 13'd0, 5'd3, r);
    queue_req(gpl_pkg::OP_APPEND, 13'(POOL + 1), 5'd31, r);
    queue_req(gpl_pkg::OP_RELEASE, 13'd0, 5'(LEVEL_TOP), r);
    queue_req(gpl_pkg::OP_RELEASE, 13'h1FFF, 5'd0, r);
    queue_req(gpl_pkg::OP_RELEASE, 13'd1, 5'd0, r);
    queue_req(gpl_pkg::OP_NOP, 13'h1FFF, 5'(LEVEL_TOP), r);
    queue_req(gpl_pkg::OP_NOP, 13'd0, 5'd31, r);
    queue_req(gpl_pkg::OP_RELEASE, 13'(POOL), 5'd2, r);
    // appending the free head cuts the free list behind it
    queue_req(gpl_pkg::OP_APPEND, 13'd3, 5'd5, r);
    queue_req(gpl_pkg::OP_ALLOC, 13'd0, 5'd5, r);
    queue_req(gpl_pkg::OP_ALLOC, 13'd0, 5'd5, r);
    queue_req(gpl_pkg::OP_ALLOC, 13'h1FFF, 5'd5, r);
    // release into an empty free list
    queue_req(gpl_pkg::OP_RELEASE, 13'd7, 5'd5, r);
    queue_req(gpl_pkg::OP_APPEND, 13'd9, 5'd5, r);
    queue_req(gpl_pkg::OP_ALLOC, 13'd0, 5'd5, r);
    queue_req(gpl_pkg::OP_ALLOC, 13'd0, 5'd0, r);
    queue_req(gpl_pkg::OP_RELEASE, 13'(POOL), 5'd0, r);
    queue_req(gpl_pkg::OP_RELEASE, 13'd10, 5'd0, r);
    queue_req(gpl_pkg::OP_RELEASE, 13'h1555, 5'd21, r);
    queue_req(gpl_pkg::OP_APPEND, 13'h0AAA, 5'd10, r);

    // random: mostly allocate, file and release of slots actually handed out
    while (sent_total < REQ_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        queue_req(gpl_pkg::OP_ALLOC, 13'($urandom_range(0, 8191)), pick_level(), r);
        if (r.granted != 13'd0) held.push_back(r.granted);
      end else if (pick < 55) begin
        s = (held.size() != 0) ? held[$urandom_range(0, held.size() - 1)]
                               : 13'($urandom_range(1, POOL));
        queue_req(gpl_pkg::OP_APPEND, s, 5'($urandom_range(0, LEVEL_TOP)), r);
      end else if (pick < 78) begin
        if (held.size() != 0) begin
          idx = $urandom_range(0, held.size() - 1);
          s = held[idx];
          held.delete(idx);
        end else begin
          s = 13'($urandom_range(1, POOL));
        end
        queue_req(gpl_pkg::OP_RELEASE, s, pick_level(), r);
      end else if (pick < 85) begin
        queue_req(gpl_pkg::OP_RELEASE, 13'($urandom_range(1, POOL)), pick_level(), r);
      end else if (pick < 91) begin
        s = ($urandom_range(0, 2) == 0) ? 13'd0 : 13'($urandom_range(POOL + 1, 8191));
        queue_req($urandom_range(0, 1) ? gpl_pkg::OP_RELEASE : gpl_pkg::OP_APPEND,
                  s, pick_level(), r);
      end else if (pick < 96) begin
        queue_req(gpl_pkg::OP_APPEND, 13'($urandom_range(0, 8191)),
                  5'($urandom_range(LEVEL_TOP + 1, 31)), r);
      end else begin
        queue_req(gpl_pkg::OP_NOP, 13'($urandom_range(0, 8191)),
                  5'($urandom_range(0, 31)), r);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_total != sent_total || due_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
